FILE: sv/hvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared types and constants for the heightmap vertex normal core.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int W_MAX   = 1024;
  localparam int R_MAX   = 4096;
  localparam int H_W     = 16;
  localparam int COL_W   = $clog2(W_MAX);
  localparam int ROW_W   = $clog2(R_MAX);
  localparam int GW_W    = 11;
  localparam int GR_W    = 13;
  localparam int CFG_W   = 13;
  localparam int SUM_W   = H_W + 3;
  localparam int SQ_W    = 2 * SUM_W - 2;
  localparam int LEN_W   = SQ_W + 2;
  localparam int ACC_W   = 74;
  localparam int Q_W     = 16;
  localparam int K_W     = 4;
  localparam int OUT_W   = 72;

  localparam logic [0:0] REG_GRID_WIDTH = 1'b0;
  localparam logic [0:0] REG_GRID_ROWS  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_LOAD, ST_SUM, ST_SQUARE, ST_LENGTH, ST_ITER, ST_OUT
  } state_t;

  typedef struct packed {
    logic           accept;
    logic           fetch;
    logic           load;
    logic           sum;
    logic           square;
    logic           init;
    logic           step;
    logic [1:0]     sel;
    logic [K_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic any;
    logic col_end;
    logic row_end;
  } status_t;

endpackage

FILE: sv/hvn_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_norm
// Scales one summed component to Q1.15, one result bit per cycle.
// ----------------------------------------------------------------------------
module hvn_norm (
  input  logic                      clk,
  input  logic                      init,
  input  logic                      step,
  input  logic [hvn_pkg::K_W-1:0]   k,
  input  logic [hvn_pkg::LEN_W-1:0] len2,
  input  logic [hvn_pkg::SQ_W-1:0]  mag2,
  input  logic                      neg,
  output logic [15:0]               result
);
  import hvn_pkg::*;

  // A tracks (2q-1)^2 * len2 and B tracks (2q-1) * len2 so each trial is
  // only shifts and adds.
  logic signed [ACC_W-1:0] acc_a;
  logic signed [ACC_W-1:0] acc_b;
  logic [LEN_W-1:0]        len_r;
  logic [SQ_W-1:0]         mag_r;
  logic                    neg_r;
  logic [Q_W-1:0]          q;

  logic signed [ACC_W-1:0] len_x;
  logic signed [ACC_W-1:0] a_next;
  logic signed [ACC_W-1:0] b_next;
  logic signed [ACC_W-1:0] target;
  logic [Q_W:0]            cand;
  logic                    take;

  always_comb begin
    len_x  = ACC_W'(len_r);
    cand   = {1'b0, q} + ((Q_W+1)'(1) << k);
    a_next = acc_a + (acc_b <<< (k + 2)) + (len_x <<< ({1'b0, k} << 1) + 2);
    b_next = acc_b + (len_x <<< (k + 1));
    target = ACC_W'({mag_r, 32'd0});
    take   = (len_r != '0) && (cand <= (Q_W+1)'(32768)) && (a_next <= target);
  end

  always_ff @(posedge clk) begin
    if (init) begin
      len_r <= len2;
      mag_r <= mag2;
      neg_r <= neg;
      acc_a <= ACC_W'(len2);
      acc_b <= -ACC_W'(len2);
      q     <= '0;
    end else if (step && take) begin
      acc_a <= a_next;
      acc_b <= b_next;
      q     <= cand[Q_W-1:0];
    end
  end

  assign result = neg_r ? 16'(-q) : (q[Q_W-1] ? 16'h7FFF : q);

endmodule

FILE: sv/hvn_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_dp
// Datapath: counters, line stores, window, face sums and normalization.
// ----------------------------------------------------------------------------
module hvn_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  hvn_pkg::cmd_t             cmd,
  output hvn_pkg::status_t          status,
  input  logic [15:0]               s_tdata,  // height
  input  logic                      s_tuser,  // start_of_frame
  output logic [hvn_pkg::OUT_W-1:0] m_tdata,  // normal_x, normal_y, normal_z,
                                              // vertex_column, vertex_row
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_addr,
  input  logic [hvn_pkg::CFG_W-1:0] cfg_wdata
);
  import hvn_pkg::*;

  logic [GW_W-1:0]  grid_width;
  logic [GR_W-1:0]  grid_rows;
  logic [GW_W-1:0]  w_sat;
  logic [GR_W-1:0]  r_sat;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [H_W-1:0]   h_r;

  logic [H_W-1:0]   upper_mem  [W_MAX];
  logic [H_W-1:0]   middle_mem [W_MAX];
  logic [H_W-1:0]   up_q;
  logic [H_W-1:0]   mid_q;
  logic [H_W-1:0]   window [6];
  logic [H_W-1:0]   g [3][3];

  logic signed [SUM_W-1:0] sx_r, sy_r, sz_r;
  logic [SQ_W-1:0]         sq_x, sq_y, sq_z;
  logic [COL_W-1:0]        vc_r;
  logic [ROW_W-1:0]        vr_r;
  logic [15:0]             nx, ny, nz;

  // Sizes saturate into the supported range.
  always_comb begin
    if (grid_width < GW_W'(2))          w_sat = GW_W'(2);
    else if (grid_width > GW_W'(W_MAX)) w_sat = GW_W'(W_MAX);
    else                                w_sat = grid_width;
    if (grid_rows < GR_W'(2))           r_sat = GR_W'(2);
    else if (grid_rows > GR_W'(R_MAX))  r_sat = GR_W'(R_MAX);
    else                                r_sat = grid_rows;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GW_W'(256);
      grid_rows  <= GR_W'(256);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_WIDTH: grid_width <= cfg_wdata[GW_W-1:0];
        REG_GRID_ROWS:  grid_rows  <= cfg_wdata[GR_W-1:0];
        default: ;
      endcase
    end
  end

  // Position of the incoming sample.
  logic [COL_W-1:0] col_c;
  logic [ROW_W-1:0] row_c;
  logic [GR_W-1:0]  row_w;
  logic [GR_W-1:0]  row_inc;

  always_comb begin
    col_c = column_count;
    row_w = GR_W'(row_count);
    if (s_tuser) begin
      col_c = '0;
      row_w = '0;
    end else if (GW_W'(column_count) >= w_sat) begin
      col_c = '0;
      row_w = GR_W'(row_count) + GR_W'(1);
    end
    if (row_w >= r_sat) row_w = '0;
    row_c   = row_w[ROW_W-1:0];
    row_inc = GR_W'(row_c) + GR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.accept) begin
      if (GW_W'(col_c) + GW_W'(1) >= w_sat) begin
        column_count <= '0;
        row_count    <= (row_inc >= r_sat) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        column_count <= col_c + COL_W'(1);
        row_count    <= row_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      h_r   <= s_tdata;
      col_r <= col_c;
      row_r <= row_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      up_q  <= upper_mem[col_r];
      mid_q <= middle_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      upper_mem[col_r]  <= mid_q;
      middle_mem[col_r] <= h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) window[i] <= '0;
    end else if (cmd.load) begin
      window[0] <= window[1];
      window[1] <= up_q;
      window[2] <= window[3];
      window[3] <= mid_q;
      window[4] <= window[5];
      window[5] <= h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int r = 0; r < 3; r++) begin
        g[r][0] <= window[2*r];
        g[r][1] <= window[2*r+1];
      end
      g[0][2] <= up_q;
      g[1][2] <= mid_q;
      g[2][2] <= h_r;
    end
  end

  assign status.any     = (row_r != '0) && (col_r != '0);
  assign status.col_end = (GW_W'(col_r) == w_sat - GW_W'(1));
  assign status.row_end = (GR_W'(row_r) == r_sat - GR_W'(1));

  // Neighborhood and face sums for the selected vertex.
  logic [GW_W-1:0] vc;
  logic [GR_W-1:0] vr;
  logic [H_W-1:0]  nb [3][3];
  logic            cell_ok [2][2];
  logic signed [SUM_W-1:0] sx, sy, sz;

  always_comb begin
    vc = cmd.sel[0] ? w_sat - GW_W'(1) : GW_W'(col_r) - GW_W'(1);
    vr = cmd.sel[1] ? GR_W'(row_r) : GR_W'(row_r) - GR_W'(1);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        nb[r][c] = '0;
        if (r + int'(cmd.sel[1]) < 3 && c + int'(cmd.sel[0]) < 3)
          nb[r][c] = g[r + int'(cmd.sel[1])][c + int'(cmd.sel[0])];
      end
    end
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        cell_ok[dr][dc] =
          ((dc == 1) ? (vc < w_sat - GW_W'(1)) : (vc != '0 && vc < w_sat)) &&
          ((dr == 1) ? (vr < r_sat - GR_W'(1)) : (vr != '0 && vr < r_sat));
      end
    end
    sx = '0;
    sy = '0;
    sz = '0;
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        if (cell_ok[dr][dc]) begin
          sx = sx + SUM_W'(nb[dr][dc]) - SUM_W'(nb[dr][dc+1]);
          sy = sy + SUM_W'(1);
          sz = sz + SUM_W'(nb[dr][dc]) - SUM_W'(nb[dr+1][dc]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sx_r <= sx;
      sy_r <= sy;
      sz_r <= sz;
      vc_r <= vc[COL_W-1:0];
      vr_r <= vr[ROW_W-1:0];
    end
  end

  logic signed [2*SUM_W-1:0] px, py, pz;
  assign px = sx_r * sx_r;
  assign py = sy_r * sy_r;
  assign pz = sz_r * sz_r;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_x <= px[SQ_W-1:0];
      sq_y <= py[SQ_W-1:0];
      sq_z <= pz[SQ_W-1:0];
    end
  end

  logic [LEN_W-1:0] len2;
  assign len2 = LEN_W'(sq_x) + LEN_W'(sq_y) + LEN_W'(sq_z);

  hvn_norm u_norm_x (
    .clk(clk), .init(cmd.init), .step(cmd.step), .k(cmd.k), .len2(len2),
    .mag2(sq_x), .neg(sx_r[SUM_W-1]), .result(nx)
  );
  hvn_norm u_norm_y (
    .clk(clk), .init(cmd.init), .step(cmd.step), .k(cmd.k), .len2(len2),
    .mag2(sq_y), .neg(sy_r[SUM_W-1]), .result(ny)
  );
  hvn_norm u_norm_z (
    .clk(clk), .init(cmd.init), .step(cmd.step), .k(cmd.k), .len2(len2),
    .mag2(sq_z), .neg(sz_r[SUM_W-1]), .result(nz)
  );

  assign m_tdata = {2'b00, vr_r, vc_r, nz, ny, nx};

endmodule

FILE: sv/hvn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_ctrl
// Sequencer: one sample at a time, up to four vertex results per sample.
// ----------------------------------------------------------------------------
module hvn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic             m_tlast,
  output hvn_pkg::cmd_t    cmd,
  input  hvn_pkg::status_t status
);
  import hvn_pkg::*;

  state_t         state, state_next;
  logic [1:0]     sel, sel_next;
  logic [K_W-1:0] k, k_next;
  logic           has_next;
  logic [1:0]     nxt;

  // The next vertex after the current one, if this sample releases more.
  always_comb begin
    has_next = 1'b0;
    nxt      = sel;
    if (sel == 2'd0 && status.col_end) begin
      has_next = 1'b1;
      nxt      = 2'd1;
    end else if ((sel == 2'd0 || sel == 2'd1) && status.row_end) begin
      has_next = 1'b1;
      nxt      = 2'd2;
    end else if (sel == 2'd2 && status.col_end && status.row_end) begin
      has_next = 1'b1;
      nxt      = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    k_next     = k;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_LOAD;
      ST_LOAD: begin
        sel_next   = 2'd0;
        state_next = status.any ? ST_SUM : ST_IDLE;
      end
      ST_SUM:    state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_LENGTH;
      ST_LENGTH: begin
        k_next     = '1;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        k_next = k - K_W'(1);
        if (k == '0) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) begin
          if (has_next) begin
            sel_next   = nxt;
            state_next = ST_SUM;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.sel    = sel;
    cmd.k      = k;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    m_tlast    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_FETCH:  cmd.fetch  = 1'b1;
      ST_LOAD:   cmd.load   = 1'b1;
      ST_SUM:    cmd.sum    = 1'b1;
      ST_SQUARE: cmd.square = 1'b1;
      ST_LENGTH: cmd.init   = 1'b1;
      ST_ITER:   cmd.step   = 1'b1;
      ST_OUT: begin
        m_tvalid = 1'b1;
        m_tlast  = !has_next;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == ST_FETCH)
    else $error("accepted sample not followed by line store read");
  a_iter_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER && k == '0) |=> state == ST_OUT)
    else $error("normalization did not finish after the last bit");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (state == ST_OUT && $stable(sel)))
    else $error("stalled result changed vertex");
`endif

endmodule

FILE: sv/heightmap_vertex_normals_core.sv
`timescale 1ns / 1ps
// After a sample is accepted the core reads the line stores and loads the window,
// then for each released vertex sums, squares, forms the length and runs the
// 16-step bit-serial normalization; up to four vertices per sample.
// Only one sample is in flight; the input is ready only between samples.
// Reset (rst, synchronous) clears counters, window and sizes (256 x 256).
// ----------------------------------------------------------------------------
// heightmap_vertex_normals_core
// Streams grid heights in raster order and emits unit vertex normals.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [15:0]               s_tdata,   // height
  input  logic                      s_tuser,   // start_of_frame
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [hvn_pkg::OUT_W-1:0] m_tdata,   // normal_x, normal_y, normal_z,
                                               // vertex_column, vertex_row
  output logic                      m_tlast,   // last_of_run
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_addr,
  input  logic [hvn_pkg::CFG_W-1:0] cfg_wdata
);
  import hvn_pkg::*;

  cmd_t    cmd;
  status_t status;

  hvn_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
    .cmd(cmd), .status(status)
  );

  hvn_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

endmodule
